// File: rtl/crc8fr_pkg.sv
// Shared constants, control/status structs and the CRC-8 byte update
// for the framed byte receiver. No dependencies.
`default_nettype none

package crc8fr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int PTR_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PLEN_W      = 6;
    localparam int BIDX_W      = 5;

    localparam logic [7:0] START_BYTE    = 8'h01;
    localparam logic [7:0] END_BYTE      = 8'h04;
    localparam logic [7:0] POLY_RESET    = 8'h07;
    localparam logic [7:0] MAX_LEN_BYTE  = 8'(MAX_PAYLOAD);

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // header byte slots, in arrival order
    localparam logic [1:0] HDR_TYPE  = 2'd0;
    localparam logic [1:0] HDR_SEQ   = 2'd1;
    localparam logic [1:0] HDR_FLAGS = 2'd2;
    localparam logic [1:0] HDR_LEN   = 2'd3;

    typedef struct packed {
        logic frame_start;
        logic hdr_wr;
        logic pay_wr;
        logic crc_wr;
        logic emit_start;
        logic out_load;
        logic idx_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic start_seen;
        logic hdr_last;
        logic len_bad;
        logic len_zero;
        logic pay_last;
        logic end_ok;
        logic emit_last;
        logic out_free;
    } dp_sts_t;

    // MSB-first CRC-8 update of one byte
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ poly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/crc8fr_ctrl.sv
// Frame receiver controller: state machine that sequences header,
// payload, CRC and end byte, then the result run. Uses crc8fr_pkg.
`default_nettype none

module crc8fr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_command,
    output logic                    s_ready,
    input  wire crc8fr_pkg::dp_sts_t sts,
    output crc8fr_pkg::dp_cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_HUNT    = 7'b0000001,
        ST_HDR     = 7'b0000010,
        ST_PAY     = 7'b0000100,
        ST_FCS     = 7'b0001000,
        ST_EOF     = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_WR = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   acc;

    always_comb begin
        s_ready = (state_reg != ST_EMIT_RD) && (state_reg != ST_EMIT_WR);
    end

    assign acc = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_EMIT_RD: begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_HUNT;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            ST_HUNT: begin
                if (acc && s_command == crc8fr_pkg::CMD_BYTE && sts.start_seen) begin
                    cmd.frame_start = 1'b1;
                    state_next      = ST_HDR;
                end
            end
            ST_HDR: begin
                if (acc) begin
                    if (s_command == crc8fr_pkg::CMD_TIMEOUT) begin
                        state_next = ST_HUNT;
                    end else if (sts.hdr_last && sts.len_bad) begin
                        state_next = ST_HUNT;
                    end else begin
                        cmd.hdr_wr = 1'b1;
                        if (sts.hdr_last) begin
                            state_next = sts.len_zero ? ST_FCS : ST_PAY;
                        end
                    end
                end
            end
            ST_PAY: begin
                if (acc) begin
                    if (s_command == crc8fr_pkg::CMD_TIMEOUT) begin
                        state_next = ST_HUNT;
                    end else begin
                        cmd.pay_wr = 1'b1;
                        if (sts.pay_last) begin
                            state_next = ST_FCS;
                        end
                    end
                end
            end
            ST_FCS: begin
                if (acc) begin
                    if (s_command == crc8fr_pkg::CMD_TIMEOUT) begin
                        state_next = ST_HUNT;
                    end else begin
                        cmd.crc_wr = 1'b1;
                        state_next = ST_EOF;
                    end
                end
            end
            ST_EOF: begin
                if (acc) begin
                    if (s_command == crc8fr_pkg::CMD_BYTE && sts.end_ok) begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT_RD;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crc8fr_dp.sv
// Frame receiver datapath: header registers, payload memory, CRC-8,
// polynomial register and result output register. Uses crc8fr_pkg.
`default_nettype none

module crc8fr_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [7:0]                        rx_byte,
    input  wire logic                              cfg_wr,
    input  wire logic [7:0]                        cfg_data,
    input  wire crc8fr_pkg::dp_cmd_t               cmd,
    output crc8fr_pkg::dp_sts_t                    sts,
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic [7:0]                             m_frame_type,
    output logic [7:0]                             m_sequence_res,
    output logic [7:0]                             m_frame_flags,
    output logic [crc8fr_pkg::PLEN_W-1:0]          m_payload_length,
    output logic [7:0]                             m_payload_byte,
    output logic [crc8fr_pkg::BIDX_W-1:0]          m_byte_index,
    output logic [7:0]                             m_received_crc,
    output logic [7:0]                             m_next_sequence,
    output logic                                   m_last
);

    localparam int LEN_W = crc8fr_pkg::LEN_W;
    localparam int PTR_W = crc8fr_pkg::PTR_W;

    logic [7:0]       poly_reg;
    logic [7:0]       crc_reg;
    logic [7:0]       fcs_reg;
    logic [1:0]       hdr_idx_reg;
    logic [7:0]       type_reg;
    logic [7:0]       seq_reg;
    logic [7:0]       flags_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic [PTR_W-1:0] idx_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       pay_mem [crc8fr_pkg::MAX_PAYLOAD];
    logic [7:0]       crc_next;
    logic             m_valid_reg;

    logic [7:0]                     out_type_reg;
    logic [7:0]                     out_seq_reg;
    logic [7:0]                     out_flags_reg;
    logic [crc8fr_pkg::PLEN_W-1:0]  out_len_reg;
    logic [7:0]                     out_byte_reg;
    logic [crc8fr_pkg::BIDX_W-1:0]  out_idx_reg;
    logic [7:0]                     out_crc_reg;
    logic [7:0]                     out_nseq_reg;
    logic                           out_last_reg;

    assign crc_next = crc8fr_pkg::crc8_feed(crc_reg, rx_byte, poly_reg);

    always_comb begin
        sts.start_seen = (rx_byte == crc8fr_pkg::START_BYTE);
        sts.hdr_last   = (hdr_idx_reg == crc8fr_pkg::HDR_LEN);
        sts.len_bad    = (rx_byte > crc8fr_pkg::MAX_LEN_BYTE);
        sts.len_zero   = (rx_byte == 8'h00);
        sts.pay_last   = (LEN_W'(cnt_reg + LEN_W'(1)) == len_reg);
        sts.end_ok     = (rx_byte == crc8fr_pkg::END_BYTE) && (fcs_reg == crc_reg);
        sts.emit_last  = (len_reg == '0) ||
                         (LEN_W'(LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg    <= crc8fr_pkg::POLY_RESET;
            crc_reg     <= '0;
            fcs_reg     <= '0;
            hdr_idx_reg <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                poly_reg <= cfg_data;
            end
            if (cmd.frame_start) begin
                crc_reg     <= '0;
                hdr_idx_reg <= '0;
                cnt_reg     <= '0;
            end
            if (cmd.hdr_wr) begin
                crc_reg     <= crc_next;
                hdr_idx_reg <= hdr_idx_reg + 2'd1;
            end
            if (cmd.pay_wr) begin
                crc_reg <= crc_next;
                cnt_reg <= cnt_reg + LEN_W'(1);
            end
            if (cmd.crc_wr) begin
                fcs_reg <= rx_byte;
            end
            if (cmd.emit_start) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + PTR_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // header capture
    always_ff @(posedge aclk) begin
        if (cmd.hdr_wr) begin
            case (hdr_idx_reg)
                crc8fr_pkg::HDR_TYPE:  type_reg  <= rx_byte;
                crc8fr_pkg::HDR_SEQ:   seq_reg   <= rx_byte;
                crc8fr_pkg::HDR_FLAGS: flags_reg <= rx_byte;
                crc8fr_pkg::HDR_LEN:   len_reg   <= LEN_W'(rx_byte);
                default:               len_reg   <= len_reg;
            endcase
        end
    end

    // payload memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.pay_wr) begin
            pay_mem[cnt_reg[PTR_W-1:0]] <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= pay_mem[idx_reg];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_type_reg  <= type_reg;
            out_seq_reg   <= seq_reg;
            out_flags_reg <= flags_reg;
            out_len_reg   <= crc8fr_pkg::PLEN_W'(len_reg);
            out_byte_reg  <= (len_reg == '0) ? 8'h00 : rd_data_reg;
            out_idx_reg   <= crc8fr_pkg::BIDX_W'(idx_reg);
            out_crc_reg   <= fcs_reg;
            out_nseq_reg  <= seq_reg + 8'd1;
            out_last_reg  <= sts.emit_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_type     = out_type_reg;
    assign m_sequence_res   = out_seq_reg;
    assign m_frame_flags    = out_flags_reg;
    assign m_payload_length = out_len_reg;
    assign m_payload_byte   = out_byte_reg;
    assign m_byte_index     = out_idx_reg;
    assign m_received_crc   = out_crc_reg;
    assign m_next_sequence  = out_nseq_reg;
    assign m_last           = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/crc8_frame_receiver_unit.sv
// Top level of the framed byte receiver with CRC-8 check.
// Instantiates crc8fr_ctrl and crc8fr_dp; uses crc8fr_pkg.
`default_nettype none

// Framed byte receiver. Each input transaction carries one received byte
// (command 0) or a timeout (command 1, drops any partial frame). The block
// hunts for the 0x01 start byte, then takes type, sequence, flags and length,
// length payload bytes (at most 32; a larger length byte sends it back to
// hunting), a CRC byte and the 0x04 end byte. The CRC-8 is MSB first, starts
// at zero, covers type through payload and uses the polynomial held in the
// configuration register (reset value 0x07, top bit implied); write it only
// while the block is idle. A frame with a wrong CRC or end byte is dropped
// without any result. A good frame gives one result transaction per payload
// byte, or one with payload_byte and byte_index zero for an empty payload;
// last marks the final one and next_sequence carries sequence + 1.
// Timing: while a frame is being received one byte is taken every cycle.
// After a good end byte s_ready stays low while the results go out: each
// result is a payload memory read, then a load of the output register, and
// that load waits while m_ready is low and the register is still full. The
// last result may still sit in the output register while the next frame is
// being received.
module crc8_frame_receiver_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // byte input
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_command,
    input  wire logic [7:0]                        s_rx_byte,
    // polynomial register write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [7:0]                        cfg_data,
    // result output
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_frame_type,
    output logic [7:0]                             m_sequence_res,
    output logic [7:0]                             m_frame_flags,
    output logic [crc8fr_pkg::PLEN_W-1:0]          m_payload_length,
    output logic [7:0]                             m_payload_byte,
    output logic [crc8fr_pkg::BIDX_W-1:0]          m_byte_index,
    output logic [7:0]                             m_received_crc,
    output logic [7:0]                             m_next_sequence,
    output logic                                   m_last
);

    crc8fr_pkg::dp_cmd_t cmd;
    crc8fr_pkg::dp_sts_t sts;

    // the register is always writable: a write transaction completes at once
    assign cfg_ready = 1'b1;

    crc8fr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    crc8fr_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .rx_byte          (s_rx_byte),
        .cfg_wr           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .sts              (sts),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_frame_type     (m_frame_type),
        .m_sequence_res   (m_sequence_res),
        .m_frame_flags    (m_frame_flags),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_byte_index     (m_byte_index),
        .m_received_crc   (m_received_crc),
        .m_next_sequence  (m_next_sequence),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

// File: rtl/crc8fr_chk.sv
// Port-level checks for crc8_frame_receiver_unit, attached by bind.
// Sees only top-level ports; uses crc8fr_pkg for field widths.
`default_nettype none

module crc8fr_chk (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [7:0]                        m_sequence_res,
    input wire logic [crc8fr_pkg::PLEN_W-1:0]     m_payload_length,
    input wire logic [7:0]                        m_payload_byte,
    input wire logic [crc8fr_pkg::BIDX_W-1:0]     m_byte_index,
    input wire logic [7:0]                        m_next_sequence,
    input wire logic                              m_last
);

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_index) &&
                                $stable(m_payload_byte) && $stable(m_last))
        else $error("stalled result changed");

    // final result sits at the end of the payload
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |->
            (m_payload_length == '0 && m_byte_index == '0) ||
            (crc8fr_pkg::PLEN_W'(m_byte_index) + crc8fr_pkg::PLEN_W'(1)
                == m_payload_length))
        else $error("last mark on wrong byte");

    // empty payload gives a zero data byte, marked last
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_length == '0 |-> m_payload_byte == 8'h00 && m_last)
        else $error("empty frame result malformed");

    // reply sequence follows the frame's own sequence
    a_next_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_next_sequence == 8'(m_sequence_res + 8'd1))
        else $error("next sequence mismatch");

endmodule

bind crc8_frame_receiver_unit crc8fr_chk u_chk (.*);

`default_nettype wire

// File: tb/crc8_frame_receiver_unit_tb.sv
// Self-checking testbench for crc8_frame_receiver_unit: framed byte stream in,
// per-payload-byte results out, checked against a cycle-free predictor.
// Depends on rtl/crc8fr_pkg.sv and rtl/crc8_frame_receiver_unit.sv.
`timescale 1ns / 1ps

module crc8_frame_receiver_unit_tb;

    // Cycles with no transaction on any channel before the run is abandoned.
    // The longest correct idle stretch is the end-of-phase pause, or a long sender
    // gap plus a long sink stall, so this is ample.
    localparam int STALL_LIMIT  = 4000;
    // Settling time after the last expected result: room for a full frame of
    // results, plus some margin.
    localparam int SETTLE_CYCLES = 2 * crc8fr_pkg::MAX_PAYLOAD + 16;
    localparam int PHASE_BYTES   = 55;

    typedef enum {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_END,
        FAULT_TIMEOUT,
        FAULT_OVERSIZE
    } frame_fault_t;

    typedef struct {
        logic        cmd;
        logic [7:0]  data;
        int unsigned gap;     // idle cycles after this transaction
    } rx_item_t;

    typedef struct packed {
        logic [7:0]                    frame_type;
        logic [7:0]                    sequence_res;
        logic [7:0]                    frame_flags;
        logic [crc8fr_pkg::PLEN_W-1:0] payload_length;
        logic [7:0]                    payload_byte;
        logic [crc8fr_pkg::BIDX_W-1:0] byte_index;
        logic [7:0]                    received_crc;
        logic [7:0]                    next_sequence;
        logic                          last;
    } frame_result_t;

    // ------------------------------------------------------------------
    // DUT signals, all bench-driven ones at known values from time zero
    // ------------------------------------------------------------------
    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic                          s_command = crc8fr_pkg::CMD_BYTE;
    logic [7:0]                    s_rx_byte = 8'h00;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [7:0]                    cfg_data  = 8'h00;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [7:0]                    m_frame_type;
    logic [7:0]                    m_sequence_res;
    logic [7:0]                    m_frame_flags;
    logic [crc8fr_pkg::PLEN_W-1:0] m_payload_length;
    logic [7:0]                    m_payload_byte;
    logic [crc8fr_pkg::BIDX_W-1:0] m_byte_index;
    logic [7:0]                    m_received_crc;
    logic [7:0]                    m_next_sequence;
    logic                          m_last;

    crc8_frame_receiver_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_rx_byte        (s_rx_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_type     (m_frame_type),
        .m_sequence_res   (m_sequence_res),
        .m_frame_flags    (m_frame_flags),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_byte_index     (m_byte_index),
        .m_received_crc   (m_received_crc),
        .m_next_sequence  (m_next_sequence),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the receiver's framing state
    // ------------------------------------------------------------------
    logic [7:0]    poly_now = crc8fr_pkg::POLY_RESET;
    int unsigned   rx_pos = 0;              // 0 = hunting for start byte
    logic [7:0]    hdr_shadow [4] = '{default: 8'h00};
    logic [7:0]    pay_shadow [crc8fr_pkg::MAX_PAYLOAD] = '{default: 8'h00};
    logic [7:0]    crc_run = 8'h00;
    logic [7:0]    crc_frame = 8'h00;
    logic [7:0]    seq_next = 8'h00;

    rx_item_t      rx_pending [$];          // bytes waiting to be driven
    frame_result_t results_due [$];         // predicted results, oldest first
    int            error_count = 0;
    int unsigned   frame_bytes_queued = 0;

    // MSB-first CRC-8, one byte
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data,
                                              input logic [7:0] poly);
        logic [7:0] acc;
        acc = crc ^ data;
        repeat (8) begin
            acc = acc[7] ? ((acc << 1) ^ poly) : (acc << 1);
        end
        return acc;
    endfunction

    // Advances the shadow state by one accepted input transaction and queues
    // any results it releases.
    task automatic rx_predict(input logic cmd, input logic [7:0] b);
        int unsigned   len;
        int unsigned   cnt;
        frame_result_t res;
        len = hdr_shadow[crc8fr_pkg::HDR_LEN];
        if (len > crc8fr_pkg::MAX_PAYLOAD) len = crc8fr_pkg::MAX_PAYLOAD;
        if (cmd == crc8fr_pkg::CMD_TIMEOUT) begin
            rx_pos = 0;
        end else if (rx_pos == 0) begin
            if (b == crc8fr_pkg::START_BYTE) begin
                crc_run = 8'h00;
                rx_pos  = 1;
            end
        end else if (rx_pos <= 4) begin
            if (rx_pos == 4 && b > crc8fr_pkg::MAX_LEN_BYTE) begin
                rx_pos = 0;
            end else begin
                hdr_shadow[rx_pos - 1] = b;
                crc_run = crc_update(crc_run, b, poly_now);
                rx_pos++;
            end
        end else if (rx_pos < 5 + len) begin
            pay_shadow[rx_pos - 5] = b;
            crc_run = crc_update(crc_run, b, poly_now);
            rx_pos++;
        end else if (rx_pos == 5 + len) begin
            crc_frame = b;
            rx_pos++;
        end else begin
            rx_pos = 0;
            if (b == crc8fr_pkg::END_BYTE && crc_frame == crc_run) begin
                seq_next = hdr_shadow[crc8fr_pkg::HDR_SEQ] + 8'd1;
                cnt = (len == 0) ? 1 : len;
                for (int unsigned k = 0; k < cnt; k++) begin
                    res.frame_type     = hdr_shadow[crc8fr_pkg::HDR_TYPE];
                    res.sequence_res   = hdr_shadow[crc8fr_pkg::HDR_SEQ];
                    res.frame_flags    = hdr_shadow[crc8fr_pkg::HDR_FLAGS];
                    res.payload_length = crc8fr_pkg::PLEN_W'(len);
                    res.payload_byte   = (len == 0) ? 8'h00 : pay_shadow[k];
                    res.byte_index     = crc8fr_pkg::BIDX_W'(k);
                    res.received_crc   = crc_frame;
                    res.next_sequence  = seq_next;
                    res.last           = (k + 1 == cnt);
                    results_due.push_back(res);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_byte(input logic cmd, input logic [7:0] data, input bit calm);
        rx_item_t it;
        it.cmd  = cmd;
        it.data = data;
        it.gap  = pick_gap(calm);
        rx_pending.push_back(it);
    endtask

    // Queues one frame, well-formed or broken as 'fault' says. For an oversize
    // fault len_byte is sent as is and the frame stops after it.
    task automatic push_frame(input logic [7:0] ftype, input logic [7:0] seq,
                              input logic [7:0] flags, input logic [7:0] len_byte,
                              input frame_fault_t fault, input bit calm);
        logic [7:0] frame [$];
        logic [7:0] crc;
        logic [7:0] tail;
        int unsigned cut;
        crc = 8'h00;
        frame.push_back(crc8fr_pkg::START_BYTE);
        frame.push_back(ftype);
        frame.push_back(seq);
        frame.push_back(flags);
        frame.push_back(len_byte);
        if (fault != FAULT_OVERSIZE) begin
            for (int i = 1; i < 5; i++) crc = crc_update(crc, frame[i], poly_now);
            for (int i = 0; i < len_byte; i++) begin
                frame.push_back(8'($urandom_range(0, 255)));
                crc = crc_update(crc, frame[frame.size() - 1], poly_now);
            end
            if (fault == FAULT_CRC) crc ^= 8'(1 << $urandom_range(0, 7));
            frame.push_back(crc);
            tail = crc8fr_pkg::END_BYTE;
            if (fault == FAULT_END) begin
                do tail = 8'($urandom_range(0, 255)); while (tail == crc8fr_pkg::END_BYTE);
            end
            frame.push_back(tail);
        end
        cut = frame.size();
        if (fault == FAULT_TIMEOUT) cut = $urandom_range(1, frame.size() - 1);
        for (int unsigned i = 0; i < cut; i++) begin
            push_byte(crc8fr_pkg::CMD_BYTE, frame[i], calm);
        end
        frame_bytes_queued += cut;
        if (fault == FAULT_TIMEOUT) begin
            push_byte(crc8fr_pkg::CMD_TIMEOUT, 8'($urandom_range(0, 255)), calm);
        end
    endtask

    // Polynomial register write on its own channel; the predictor follows on
    // acceptance. Only called while the receiver is idle.
    task automatic write_polynomial(input logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        poly_now = value;
    endtask

    // Sampled on the falling edge so that the driver's updates at the rising
    // edge have settled.
    task automatic wait_drained();
        do @(negedge aclk); while (rx_pending.size() != 0 || s_valid || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: pops the pending queue, holds each transaction until it
    // is accepted, predicts on acceptance.
    // ------------------------------------------------------------------
    rx_item_t    item_now;
    int unsigned wait_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            wait_left = 0;
        end else begin
            if (s_valid && s_ready) rx_predict(s_command, s_rx_byte);
            if (!s_valid || s_ready) begin
                if (wait_left > 0) begin
                    wait_left--;
                    s_valid <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    item_now  = rx_pending.pop_front();
                    s_valid   <= 1'b1;
                    s_command <= item_now.cmd;
                    s_rx_byte <= item_now.data;
                    wait_left = item_now.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: long stretches of ready, short and occasional long stalls
    // ------------------------------------------------------------------
    int unsigned sink_hold = 0;
    int unsigned sink_pick;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_hold = 0;
        end else if (sink_hold > 0) begin
            sink_hold--;
        end else begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 20) begin
                m_ready   <= 1'b1;
                sink_hold = $urandom_range(30, 80);
            end else if (sink_pick < 75) begin
                m_ready   <= 1'b1;
                sink_hold = $urandom_range(0, 3);
            end else if (sink_pick < 95) begin
                m_ready   <= 1'b0;
                sink_hold = $urandom_range(0, 2);
            end else begin
                m_ready   <= 1'b0;
                sink_hold = $urandom_range(10, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            error_count++;
        end
    endtask

    frame_result_t res_want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $error("result transaction with nothing expected (type 0x%02h index %0d)",
                       m_frame_type, m_byte_index);
                error_count++;
            end else begin
                res_want = results_due.pop_front();
                check_field("frame_type",     res_want.frame_type,     m_frame_type);
                check_field("sequence_res",   res_want.sequence_res,   m_sequence_res);
                check_field("frame_flags",    res_want.frame_flags,    m_frame_flags);
                check_field("payload_length", 8'(res_want.payload_length), 8'(m_payload_length));
                check_field("payload_byte",   res_want.payload_byte,   m_payload_byte);
                check_field("byte_index",     8'(res_want.byte_index), 8'(m_byte_index));
                check_field("received_crc",   res_want.received_crc,   m_received_crc);
                check_field("next_sequence",  res_want.next_sequence,  m_next_sequence);
                check_field("last",           8'(res_want.last),       8'(m_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any transaction on any channel
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases, one polynomial each
    // ------------------------------------------------------------------
    logic [7:0]   poly_plan [4];
    int unsigned  phase_start;
    int unsigned  pick;
    int unsigned  noise_n;
    logic [7:0]   len_pick;
    logic [7:0]   noise_byte;
    frame_fault_t fault_pick;

    initial begin
        poly_plan[0] = crc8fr_pkg::POLY_RESET;
        poly_plan[1] = 8'h00;
        poly_plan[2] = 8'hFF;
        poly_plan[3] = 8'($urandom_range(1, 254));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            write_polynomial(poly_plan[p]);

            if (p == 0) begin
                // bytes while hunting are ignored
                push_byte(crc8fr_pkg::CMD_BYTE, 8'h00, 1'b0);
                push_byte(crc8fr_pkg::CMD_BYTE, 8'hFE, 1'b0);
                // empty payload, all-ones type and sequence, sequence wraps to zero
                push_frame(8'hFF, 8'hFF, 8'h00, 8'd0, FAULT_NONE, 1'b0);
                // timeout part way through a header, rx_byte all ones
                push_byte(crc8fr_pkg::CMD_BYTE, crc8fr_pkg::START_BYTE, 1'b0);
                push_byte(crc8fr_pkg::CMD_BYTE, 8'h00, 1'b0);
                push_byte(crc8fr_pkg::CMD_TIMEOUT, 8'hFF, 1'b0);
                // length one above the maximum
                push_frame(8'h00, 8'h00, 8'h00, crc8fr_pkg::MAX_LEN_BYTE + 8'd1,
                           FAULT_OVERSIZE, 1'b0);
                // bad CRC on an otherwise good empty frame
                push_frame(8'h80, 8'h00, 8'hFF, 8'd0, FAULT_CRC, 1'b0);
            end

            phase_start = frame_bytes_queued;
            while (frame_bytes_queued - phase_start < PHASE_BYTES) begin
                // occasional line noise between frames
                if ($urandom_range(0, 99) < 15) begin
                    noise_n = $urandom_range(1, 3);
                    repeat (noise_n) begin
                        if ($urandom_range(0, 1)) begin
                            push_byte(crc8fr_pkg::CMD_TIMEOUT, 8'($urandom_range(0, 255)),
                                      1'b0);
                        end else begin
                            do noise_byte = 8'($urandom_range(0, 255));
                            while (noise_byte == crc8fr_pkg::START_BYTE);
                            push_byte(crc8fr_pkg::CMD_BYTE, noise_byte, 1'b0);
                        end
                    end
                end
                pick = $urandom_range(0, 99);
                if (pick < 70)      fault_pick = FAULT_NONE;
                else if (pick < 78) fault_pick = FAULT_CRC;
                else if (pick < 85) fault_pick = FAULT_END;
                else if (pick < 93) fault_pick = FAULT_TIMEOUT;
                else                fault_pick = FAULT_OVERSIZE;
                // mostly short payloads; empty and full-size now and then
                pick = $urandom_range(0, 99);
                if (fault_pick == FAULT_OVERSIZE) begin
                    len_pick = 8'($urandom_range(crc8fr_pkg::MAX_PAYLOAD + 1, 255));
                end else if (pick < 10) begin
                    len_pick = 8'd0;
                end else if (pick < 18) begin
                    len_pick = crc8fr_pkg::MAX_LEN_BYTE;
                end else begin
                    len_pick = 8'($urandom_range(1, 8));
                end
                push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), len_pick, fault_pick,
                           $urandom_range(0, 4) == 0);
            end
            // leave the receiver hunting before the next register write
            push_byte(crc8fr_pkg::CMD_TIMEOUT, 8'($urandom_range(0, 255)), 1'b0);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/crc8fr_pkg.sv
rtl/crc8fr_ctrl.sv
rtl/crc8fr_dp.sv
rtl/crc8_frame_receiver_unit.sv
rtl/crc8fr_chk.sv
tb/crc8_frame_receiver_unit_tb.sv
